// ===== hw/rtl/sample_variance_stddev_macros.svh =====
// Assertion macros shared by the sample variance block.
`ifndef SAMPLE_VARIANCE_STDDEV_MACROS_SVH
`define SAMPLE_VARIANCE_STDDEV_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/svs_pkg.sv =====
package svs_pkg;

    localparam int MAX_SAMPLES_DEF  = 65536;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int S_TDATA_W   = 16;
    localparam int RES_W       = 32;
    localparam int RT_W        = RES_W / 2;
    localparam int COUNT_OUT_W = 17;
    localparam int M_TDATA_W   = 56;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        MODE_VARIANCE = 1'b0,
        MODE_STDDEV   = 1'b1
    } result_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SQ,
        ST_MUL_DEN,
        ST_SUB,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } back_state_t;

endpackage

// ===== hw/rtl/svs_front.sv =====
module svs_front #(
    parameter int MAX_SAMPLES  = 65536,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ENTRY_W      = 98
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [svs_pkg::S_TDATA_W-1:0] s_sample,
    input  logic                          s_last,
    output logic                          q_wr_en,
    output logic [ENTRY_W-1:0]            q_wr_data,
    input  logic                          q_full
);
    import svs_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_WIDTH - 2 + CNT_W;
    localparam int SQR_W = 2 * SAMPLE_WIDTH - 1;

    logic signed [SAMPLE_WIDTH-1:0]   smp;
    logic signed [2*SAMPLE_WIDTH-1:0] smp_prod;
    logic                             accept;
    logic                             advance;

    logic                             p_valid_reg, p_valid_next;
    logic                             p_last_reg;
    logic signed [SAMPLE_WIDTH-1:0]   p_sample_reg;
    logic [SQR_W-1:0]                 p_square_reg;

    logic signed [SUM_W-1:0]          sum_reg, sum_next;
    logic [SQ_W-1:0]                  sq_reg, sq_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             ovf_reg, ovf_next;

    logic                             room;
    logic signed [SUM_W-1:0]          acc_sum;
    logic [SQ_W-1:0]                  acc_sq;
    logic [CNT_W-1:0]                 acc_cnt;
    logic                             acc_ovf;

    assign smp      = s_sample[SAMPLE_WIDTH-1:0];
    assign smp_prod = smp * smp;

    assign advance = p_valid_reg && (!p_last_reg || !q_full);
    assign s_ready = !p_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign room    = cnt_reg < CNT_W'(MAX_SAMPLES);
    assign acc_sum = room ? sum_reg + {{(SUM_W-SAMPLE_WIDTH){p_sample_reg[SAMPLE_WIDTH-1]}},
                                       p_sample_reg}
                          : sum_reg;
    assign acc_sq  = room ? sq_reg + SQ_W'(p_square_reg) : sq_reg;
    assign acc_cnt = room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign acc_ovf = ovf_reg | !room;

    assign q_wr_en   = advance && p_last_reg;
    assign q_wr_data = {acc_ovf, acc_cnt, acc_sq, acc_sum};

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (advance) begin
            p_valid_next = 1'b0;
        end
    end

    always_comb begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (advance) begin
            if (p_last_reg) begin
                sum_next = '0;
                sq_next  = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end else begin
                sum_next = acc_sum;
                sq_next  = acc_sq;
                cnt_next = acc_cnt;
                ovf_next = acc_ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_last_reg   <= s_last;
            p_sample_reg <= smp;
            p_square_reg <= smp_prod[SQR_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/svs_fifo.sv =====
module svs_fifo #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import svs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/svs_back.sv =====
module svs_back #(
    parameter int MAX_SAMPLES  = 65536,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ENTRY_W      = 98
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  svs_pkg::result_mode_t           result_mode,
    output logic                            q_rd_en,
    input  logic [ENTRY_W-1:0]              q_rd_data,
    input  logic                            q_empty,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [svs_pkg::RES_W-1:0]       m_result,
    output logic [svs_pkg::COUNT_OUT_W-1:0] m_count,
    output logic                            m_overflow
);
    import svs_pkg::*;

    `include "sample_variance_stddev_macros.svh"

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_WIDTH + CNT_W;
    localparam int MAG_W   = SUM_W - 1;
    localparam int SQ_W    = 2 * SAMPLE_WIDTH - 2 + CNT_W;
    localparam int SQ_LO_W = (SQ_W + 1) / 2;
    localparam int NSQ_W   = SQ_W + CNT_W;
    localparam int SSQ_W   = 2 * MAG_W;
    localparam int NUM_W   = (NSQ_W > SSQ_W) ? NSQ_W : SSQ_W;
    localparam int QX_W    = (NUM_W > RES_W) ? NUM_W : RES_W + 1;
    localparam int DEN_W   = 2 * CNT_W;
    localparam int STEP_W  = $clog2(NUM_W + RT_W);

    back_state_t             state_reg, state_next;

    logic signed [SUM_W-1:0] e_sum;
    logic [SQ_W-1:0]         e_sq;
    logic [CNT_W-1:0]        e_cnt;
    logic                    e_ovf;

    logic [CNT_W-1:0]        n_reg, n_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    ovf_reg, ovf_next;
    logic [NUM_W-1:0]        nsq_reg, nsq_next;
    logic [NUM_W-1:0]        ssq_reg, ssq_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        div_rem_reg, div_rem_next;
    logic [NUM_W-1:0]        div_q_reg, div_q_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [RES_W-1:0]        rt_x_reg, rt_x_next;
    logic [RT_W:0]           rt_rem_reg, rt_rem_next;
    logic [RT_W-1:0]         rt_root_reg, rt_root_next;
    logic [RES_W-1:0]        res_reg, res_next;

    logic                    m_valid_reg, m_valid_next;
    logic [RES_W-1:0]        m_result_reg;
    logic [COUNT_OUT_W-1:0]  m_count_reg;
    logic                    m_ovf_reg;
    logic                    out_load;

    logic signed [SUM_W-1:0] neg_sum;
    logic [DEN_W:0]          div_shift;
    logic                    div_bit;
    logic [NUM_W-1:0]        div_q_step;
    logic [QX_W-1:0]         quot_ext;
    logic [RES_W-1:0]        var_sat;
    logic [RT_W+2:0]         rt_shift;
    logic [RT_W+2:0]         rt_trial;
    logic                    rt_bit;
    logic [RT_W-1:0]         rt_root_step;

    assign {e_ovf, e_cnt, e_sq, e_sum} = q_rd_data;
    assign neg_sum = -e_sum;

    assign div_shift  = {div_rem_reg, div_q_reg[NUM_W-1]};
    assign div_bit    = div_shift >= {1'b0, den_reg};
    assign div_q_step = {div_q_reg[NUM_W-2:0], div_bit};
    assign quot_ext   = QX_W'(div_q_step);
    assign var_sat    = (|quot_ext[QX_W-1:RES_W]) ? '1 : quot_ext[RES_W-1:0];

    assign rt_shift     = {rt_rem_reg, rt_x_reg[RES_W-1:RES_W-2]};
    assign rt_trial     = {1'b0, rt_root_reg, 2'b01};
    assign rt_bit       = rt_shift >= rt_trial;
    assign rt_root_step = {rt_root_reg[RT_W-2:0], rt_bit};

    assign q_rd_en  = (state_reg == ST_IDLE) && !q_empty;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_MUL_SQ;
            ST_MUL_SQ:  state_next = ST_MUL_DEN;
            ST_MUL_DEN: state_next = ST_SUB;
            ST_SUB: begin
                state_next = (n_reg > CNT_W'(1)) ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    state_next = (result_mode == MODE_STDDEV) ? ST_SQRT : ST_DONE;
                end
            end
            ST_SQRT: begin
                if (step_reg == STEP_W'(RT_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        n_next       = n_reg;
        sq_next      = sq_reg;
        mag_next     = mag_reg;
        ovf_next     = ovf_reg;
        nsq_next     = nsq_reg;
        ssq_next     = ssq_reg;
        den_next     = den_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        step_next    = step_reg;
        rt_x_next    = rt_x_reg;
        rt_rem_next  = rt_rem_reg;
        rt_root_next = rt_root_reg;
        res_next     = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                n_next   = e_cnt;
                sq_next  = e_sq;
                ovf_next = e_ovf;
                mag_next = e_sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : e_sum[MAG_W-1:0];
            end
            ST_MUL_LO: begin
                nsq_next = NUM_W'(n_reg * sq_reg[SQ_LO_W-1:0]);
            end
            ST_MUL_HI: begin
                nsq_next = nsq_reg + (NUM_W'(n_reg * sq_reg[SQ_W-1:SQ_LO_W]) << SQ_LO_W);
            end
            ST_MUL_SQ: begin
                ssq_next = NUM_W'(mag_reg * mag_reg);
            end
            ST_MUL_DEN: begin
                den_next = n_reg * (n_reg - CNT_W'(1));
            end
            ST_SUB: begin
                div_q_next   = (nsq_reg > ssq_reg) ? nsq_reg - ssq_reg : '0;
                div_rem_next = '0;
                step_next    = '0;
                res_next     = '0;
            end
            ST_DIV: begin
                div_rem_next = div_bit ? DEN_W'(div_shift - {1'b0, den_reg})
                                       : div_shift[DEN_W-1:0];
                div_q_next   = div_q_step;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1)) begin
                    res_next     = var_sat;
                    rt_x_next    = var_sat;
                    rt_rem_next  = '0;
                    rt_root_next = '0;
                    step_next    = '0;
                end
            end
            ST_SQRT: begin
                rt_rem_next  = rt_bit ? (RT_W + 1)'(rt_shift - rt_trial)
                                      : rt_shift[RT_W:0];
                rt_root_next = rt_root_step;
                rt_x_next    = {rt_x_reg[RES_W-3:0], 2'b00};
                step_next    = step_reg + STEP_W'(1);
                res_next     = RES_W'(rt_root_step);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        sq_reg      <= sq_next;
        mag_reg     <= mag_next;
        ovf_reg     <= ovf_next;
        nsq_reg     <= nsq_next;
        ssq_reg     <= ssq_next;
        den_reg     <= den_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        step_reg    <= step_next;
        rt_x_reg    <= rt_x_next;
        rt_rem_reg  <= rt_rem_next;
        rt_root_reg <= rt_root_next;
        res_reg     <= res_next;
        if (out_load) begin
            m_result_reg <= res_reg;
            m_count_reg  <= COUNT_OUT_W'(n_reg);
            m_ovf_reg    <= ovf_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_result   = m_result_reg;
    assign m_count    = m_count_reg;
    assign m_overflow = m_ovf_reg;

    `SVS_ASSERT_IMP(a_den_nonzero, aclk, aresetn, state_reg == ST_DIV, den_reg != '0, "divide started with a zero divisor")
    `SVS_ASSERT_NXT(a_pop_starts, aclk, aresetn, q_rd_en, state_reg == ST_MUL_LO, "queue pop did not start the multiply sequence")
    `SVS_ASSERT_NXT(a_count_range, aclk, aresetn, out_load, m_count_reg <= COUNT_OUT_W'(MAX_SAMPLES), "reported count exceeds the sample limit")

endmodule

// ===== hw/rtl/sample_variance_stddev.sv =====
// Sample variance and standard deviation over sets of signed samples.
// The slave stream carries one sample per item in s_tdata; s_tlast marks the
// final sample of a set. Samples are accepted one per cycle while the
// accumulator stage can move on.
// For each set the master stream returns one item: the unbiased variance, or
// its integer square root when the mode register is set, together with the
// sample count and an overflow flag in m_tuser.
// The mode register is written through the cfg channel, which is always ready.
// A closed set passes into a two-entry queue and the result engine works it
// off: four multiply steps and a subtract, one bit of the 64-bit quotient per
// cycle in the divider and, in deviation mode, 16 root steps; sets of fewer
// than two samples skip both and give zero. Sets that come faster than the
// engine works them off stall the slave stream once the queue is full.
// A stalled master stream holds its item and stops the result engine, while
// sample accumulation continues until the queue fills.
// Reset clears the accumulators, the queue and the output and selects
// variance mode.
module sample_variance_stddev #(
    parameter int MAX_SAMPLES  = svs_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_WIDTH = svs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [svs_pkg::S_TDATA_W-1:0] s_tdata,   // sample
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [svs_pkg::M_TDATA_W-1:0] m_tdata,   // result, sample_count
    output logic                          m_tuser    // overflow
);
    import svs_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_WIDTH + CNT_W;
    localparam int SQ_W    = 2 * SAMPLE_WIDTH - 2 + CNT_W;
    localparam int ENTRY_W = SUM_W + SQ_W + CNT_W + 1;
    localparam int PAD_W   = M_TDATA_W - RES_W - COUNT_OUT_W;

    result_mode_t           mode_reg, mode_next;
    logic                   q_wr_en;
    logic [ENTRY_W-1:0]     q_wr_data;
    logic                   q_full;
    logic                   q_rd_en;
    logic [ENTRY_W-1:0]     q_rd_data;
    logic                   q_empty;
    logic [RES_W-1:0]       result;
    logic [COUNT_OUT_W-1:0] sample_count;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? result_mode_t'(cfg_data) : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_VARIANCE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    svs_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_sample  (s_tdata),
        .s_last    (s_tlast),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .q_full    (q_full)
    );

    svs_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    svs_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .result_mode (mode_reg),
        .q_rd_en     (q_rd_en),
        .q_rd_data   (q_rd_data),
        .q_empty     (q_empty),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result),
        .m_count     (sample_count),
        .m_overflow  (m_tuser)
    );

    assign m_tdata = {{PAD_W{1'b0}}, sample_count, result};

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import svs_pkg::*;

    localparam int SAMPLE_LIMIT = MAX_SAMPLES_DEF;

    typedef struct {
        bit [RES_W-1:0]       value;
        bit [COUNT_OUT_W-1:0] count;
        bit                   saturated;
    } set_stats_t;

    class variance_scoreboard;
        result_mode_t mode = MODE_VARIANCE;
        longint       sum_acc;
        bit [63:0]    sumsq_acc;
        int           count_acc;
        bit           over_limit;
        set_stats_t   expected_stats[$];
        int           mismatches;

        function bit [31:0] int_root(bit [63:0] x);
            bit [31:0] r;
            bit [63:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = {32'd0, r | (32'd1 << b)};
                if (t * t <= x) begin
                    r = t[31:0];
                end
            end
            return r;
        endfunction

        function void note_sample(logic [S_TDATA_W-1:0] smp, logic is_last);
            longint    s;
            bit [63:0] n, mag, nsq, ssq, num, den, var_q;
            set_stats_t st;
            s = longint'($signed(smp));
            if (count_acc < SAMPLE_LIMIT) begin
                sum_acc   += s;
                sumsq_acc += 64'(s * s);
                count_acc++;
            end else begin
                over_limit = 1;
            end
            if (!is_last) begin
                return;
            end
            st.value = 0;
            n = 64'(count_acc);
            if (n > 1) begin
                mag   = (sum_acc < 0) ? 64'(-sum_acc) : 64'(sum_acc);
                nsq   = n * sumsq_acc;
                ssq   = mag * mag;
                num   = (nsq > ssq) ? nsq - ssq : 64'd0;
                den   = n * (n - 1);
                var_q = num / den;
                if (var_q > 64'hFFFF_FFFF) begin
                    var_q = 64'hFFFF_FFFF;
                end
                st.value = (mode == MODE_STDDEV) ? int_root(var_q) : var_q[31:0];
            end
            st.count     = COUNT_OUT_W'(count_acc);
            st.saturated = over_limit;
            expected_stats.push_back(st);
            sum_acc    = 0;
            sumsq_acc  = 0;
            count_acc  = 0;
            over_limit = 0;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic user);
            set_stats_t st;
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result item with none expected: value %0d count %0d ovf %0b",
                             $time, data[31:0], data[48:32], user);
                end
                return;
            end
            st = expected_stats.pop_front();
            if (data[31:0] !== st.value || data[48:32] !== st.count
                    || user !== st.saturated) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch: expected value %0d count %0d ovf %0b, got %0d %0d %0b",
                             $time, st.value, st.count, st.saturated,
                             data[31:0], data[48:32], user);
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    bit sender_idles;
    bit receiver_stalls;

    variance_scoreboard sb = new;

    sample_variance_stddev dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= receiver_stalls ? ($urandom_range(0, 99) >= 35) : 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_tvalid && s_tready) begin
            sb.note_sample(s_tdata, s_tlast);
        end
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    task automatic push_sample(input logic [S_TDATA_W-1:0] smp, input bit is_last);
        while (sender_idles && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.expected_stats.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_mode(input result_mode_t md);
        wait_for_results();
        repeat (120) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= md;
        do @(posedge aclk); while (!cfg_ready);
        sb.mode = md;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [S_TDATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return S_TDATA_W'($urandom_range(0, 15) - 8);
            default: return S_TDATA_W'($urandom);
        endcase
    endfunction

    task automatic run_random_sets(input int budget, input bit pause_midway);
        int sent;
        int len;
        bit paused;
        sent   = 0;
        paused = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
            for (int k = 0; k < len; k++) begin
                push_sample(pick_sample(), k == len - 1);
            end
            sent += len;
            if (pause_midway && !paused && sent >= budget / 2) begin
                wait_for_results();
                paused = 1;
            end
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_data        <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tlast         <= 1'b0;
        sender_idles    = 1;
        receiver_stalls = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_sample(16'h7FFF, 1);
        push_sample(16'h8000, 0);
        push_sample(16'h7FFF, 1);
        push_sample(16'h8000, 0);
        push_sample(16'h8000, 0);
        push_sample(16'h8000, 1);
        push_sample(16'h0000, 0);
        push_sample(16'h0000, 1);
        push_sample(16'h0001, 0);
        push_sample(16'hFFFF, 0);
        push_sample(16'h0001, 0);
        push_sample(16'hFFFF, 1);
        push_sample(16'h5555, 0);
        push_sample(16'hAAAA, 0);
        push_sample(16'h7FFF, 0);
        push_sample(16'h8000, 0);
        push_sample(16'h0000, 1);
        push_sample(16'h1234, 1);
        push_sample(16'hFFFF, 0);
        push_sample(16'h0003, 0);
        push_sample(16'h00FF, 0);
        push_sample(16'hFF00, 0);
        push_sample(16'h7FFE, 1);

        write_mode(MODE_STDDEV);
        run_random_sets(190, 0);

        write_mode(MODE_VARIANCE);
        sender_idles    = 0;
        receiver_stalls = 0;
        run_random_sets(180, 1);

        write_mode(MODE_STDDEV);
        sender_idles    = 1;
        receiver_stalls = 1;
        run_random_sets(190, 0);

        write_mode(MODE_VARIANCE);
        run_random_sets(40, 0);

        wait_for_results();
        repeat (120) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_stats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #16000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
